>>> src/thmj_pkg.sv
// Shared types, constants and fixed-point helpers for the trilinear hexahedral
// element map and Jacobian block. No dependencies.
`timescale 1ns / 1ps

package thmj_pkg;

    // Element and number format
    localparam int NODE_COUNT      = 8;
    localparam int NODE_IDX_W      = $clog2(NODE_COUNT);
    localparam int LOCAL_FRAC_BITS = 16;
    localparam int LOCAL_W         = 17;
    localparam int COORD_W         = 32;
    localparam int OUT_W           = 40;
    localparam int AXES            = 3;
    localparam int WEIGHT_KINDS    = 4;
    localparam int OUT_FIELDS      = AXES * WEIGHT_KINDS;

    // Derived widths
    localparam int FW      = LOCAL_FRAC_BITS + 1;
    localparam int PROD_W  = 2 * FW;
    localparam int WW      = FW + 1;
    localparam int PW      = COORD_W + WW;
    localparam int ACC_W   = PW + $clog2(NODE_COUNT);
    localparam int RND_W   = LOCAL_FRAC_BITS + OUT_W;
    localparam int CLAMP_W = (LOCAL_W > FW) ? LOCAL_W : FW;
    localparam int ONE     = 1 << LOCAL_FRAC_BITS;
    localparam int HALF    = 1 << (LOCAL_FRAC_BITS - 1);

    typedef logic [FW-1:0]            factor_t;
    typedef logic [PROD_W-1:0]        prod_u_t;
    typedef logic signed [WW-1:0]     weight_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PW-1:0]     prod_s_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [OUT_W-1:0]  out_word_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } node_t;

    // Control that travels with one node beat down the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } beat_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } fsm_state_t;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } func_t;

    // Clamp a local coordinate to 1.0
    function automatic factor_t clamp_local(input logic [LOCAL_W-1:0] v);
        logic [CLAMP_W-1:0] ve;
        ve = CLAMP_W'(v);
        if (ve > CLAMP_W'(ONE))
            ve = CLAMP_W'(ONE);
        return FW'(ve);
    endfunction

    // Round half up of a non-negative product of two Q1.F factors back to Q1.F
    function automatic factor_t rnd_q(input prod_u_t p);
        prod_u_t s;
        s = p + PROD_W'(HALF);
        return s[LOCAL_FRAC_BITS+FW-1:LOCAL_FRAC_BITS];
    endfunction

    // Round half up with arithmetic shift, keep the low output bits
    function automatic out_word_t rnd_out(input acc_t acc);
        logic [RND_W-1:0] s;
        s = {{(RND_W-ACC_W){acc[ACC_W-1]}}, acc} + RND_W'(HALF);
        return s[RND_W-1:LOCAL_FRAC_BITS];
    endfunction

endpackage

>>> src/trilinear_hex_map_jacobian.sv
// Top level of the trilinear hexahedral element map and Jacobian block:
// sequencer, node memory, weight pipeline, accumulators and output register.
// Depends on thmj_pkg, thmj_node_mem, thmj_weight and thmj_mac.
//
// Usage:
//   Input channel (in_valid / in_stall): func = 0 loads one node's x, y, z
//   into slot node_index; func = 1 evaluates at local point (ksi, nu, etta),
//   each clamped to 1.0. All eight nodes must be loaded before an evaluate.
//   Output channel (out_valid / out_stall): one beat per evaluate carrying
//   the mapped point and the 3x3 Jacobian, all signed Q24.16, 40 bits.
//   Loads: one per cycle while the sequencer is idle, no result.
//   Evaluate: the sequencer reads the eight nodes from the node memory, one
//   per cycle, through a two-stage weight pipeline and a product stage into
//   twelve accumulators. The input is stalled from acceptance until the
//   result is taken into the output register, so no new evaluate starts
//   before the last is through; the single read port serialises the reads.
//   The output register holds a finished result while the receiver stalls;
//   loads are taken meanwhile, and an evaluate may run but its result waits
//   in the accumulators until the output register frees up.
//   Reset clears the sequencer and all valid flags; node contents are
//   undefined until loaded.
`timescale 1ns / 1ps

module trilinear_hex_map_jacobian
    import thmj_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [2:0]                node_index,
    input  logic signed [COORD_W-1:0] node_x,
    input  logic signed [COORD_W-1:0] node_y,
    input  logic signed [COORD_W-1:0] node_z,
    input  logic [LOCAL_W-1:0]        ksi,
    input  logic [LOCAL_W-1:0]        nu,
    input  logic [LOCAL_W-1:0]        etta,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   jac_ksi_x,
    output logic signed [OUT_W-1:0]   jac_ksi_y,
    output logic signed [OUT_W-1:0]   jac_ksi_z,
    output logic signed [OUT_W-1:0]   jac_nu_x,
    output logic signed [OUT_W-1:0]   jac_nu_y,
    output logic signed [OUT_W-1:0]   jac_nu_z,
    output logic signed [OUT_W-1:0]   jac_etta_x,
    output logic signed [OUT_W-1:0]   jac_etta_y,
    output logic signed [OUT_W-1:0]   jac_etta_z,
    output logic signed [OUT_W-1:0]   map_x,
    output logic signed [OUT_W-1:0]   map_y,
    output logic signed [OUT_W-1:0]   map_z
);

    localparam logic [NODE_IDX_W-1:0] LAST_NODE = NODE_IDX_W'(NODE_COUNT - 1);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic [NODE_IDX_W-1:0] cnt_reg;
    logic [NODE_IDX_W-1:0] cnt_next;

    logic accept;
    logic load_wr;
    logic eval_start;
    logic take;

    factor_t tk_reg;
    factor_t tn_reg;
    factor_t te_reg;

    node_t      wr_node;
    node_t      rd_node;
    node_t      coord_d_reg;
    logic       mem_rd_en;
    beat_ctrl_t issue_ctrl;

    beat_ctrl_t w_ctrl;
    weight_t    w_ksi;
    weight_t    w_nu;
    weight_t    w_etta;
    weight_t    w_map;

    logic      mac_done;
    out_word_t mac_res [OUT_FIELDS];

    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t res_reg [OUT_FIELDS];

    // Input handshake decode
    always_comb
    begin
        accept     = in_valid && !in_stall;
        load_wr    = accept && (func_t'(func) == FUNC_LOAD);
        eval_start = accept && (func_t'(func) == FUNC_EVAL);
        take       = mac_done && (!out_valid_reg || !out_stall);
        wr_node.x  = node_x;
        wr_node.y  = node_y;
        wr_node.z  = node_z;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cnt_reg == LAST_NODE)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall         = 1'b1;
        mem_rd_en        = 1'b0;
        issue_ctrl       = '0;
        cnt_next         = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cnt_next = '0;
            end
            ST_RUN:
            begin
                mem_rd_en        = 1'b1;
                issue_ctrl.valid = 1'b1;
                issue_ctrl.first = (cnt_reg == '0);
                issue_ctrl.last  = (cnt_reg == LAST_NODE);
                cnt_next         = cnt_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                cnt_next = '0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the clamped local point for the whole evaluate
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            tk_reg <= clamp_local(ksi);
            tn_reg <= clamp_local(nu);
            te_reg <= clamp_local(etta);
        end
    end

    thmj_node_mem u_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (node_index),
        .wr_data (wr_node),
        .rd_en   (mem_rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_node)
    );

    // Register the read data once more to line up with the weights
    always_ff @(posedge clk)
    begin
        coord_d_reg <= rd_node;
    end

    thmj_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (issue_ctrl),
        .node     (cnt_reg),
        .t_ksi    (tk_reg),
        .t_nu     (tn_reg),
        .t_etta   (te_reg),
        .out_ctrl (w_ctrl),
        .w_ksi    (w_ksi),
        .w_nu     (w_nu),
        .w_etta   (w_etta),
        .w_map    (w_map)
    );

    thmj_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctrl (w_ctrl),
        .coord   (coord_d_reg),
        .w_ksi   (w_ksi),
        .w_nu    (w_nu),
        .w_etta  (w_etta),
        .w_map   (w_map),
        .clear   (take),
        .done    (mac_done),
        .res     (mac_res)
    );

    // Output beat valid: set on take, drop once the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < OUT_FIELDS; i++)
                res_reg[i] <= mac_res[i];
        end
    end

    assign out_valid  = out_valid_reg;
    assign jac_ksi_x  = res_reg[0];
    assign jac_ksi_y  = res_reg[1];
    assign jac_ksi_z  = res_reg[2];
    assign jac_nu_x   = res_reg[3];
    assign jac_nu_y   = res_reg[4];
    assign jac_nu_z   = res_reg[5];
    assign jac_etta_x = res_reg[6];
    assign jac_etta_y = res_reg[7];
    assign jac_etta_z = res_reg[8];
    assign map_x      = res_reg[9];
    assign map_y      = res_reg[10];
    assign map_z      = res_reg[11];

    // Loads and node reads never share a cycle
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_wr && mem_rd_en))
        else $error("node memory written and read in the same cycle");

    // After the last node read the sequencer drains
    a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_reg == LAST_NODE) |=> state_reg == ST_DRAIN)
        else $error("sequencer did not drain after the last node");

    // Finished sums never linger while idle
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mac_done)
        else $error("accumulator result pending in idle");

    // A new output beat comes only from a finished evaluate
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(mac_done))
        else $error("output valid without a finished evaluate");

endmodule

>>> src/thmj_node_mem.sv
// Node coordinate memory: eight entries of x, y, z, one write and one read
// port, read data registered. Depends on thmj_pkg.
`timescale 1ns / 1ps

module thmj_node_mem
    import thmj_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [NODE_IDX_W-1:0] wr_addr,
    input  node_t                 wr_data,
    input  logic                  rd_en,
    input  logic [NODE_IDX_W-1:0] rd_addr,
    output node_t                 rd_data
);

    node_t mem [NODE_COUNT];
    node_t rd_data_reg;

    // Write one node
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read one node into the registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/thmj_weight.sv
// Per-node shape weights: two registered stages that form the shape function
// and its three signed derivative weights. Depends on thmj_pkg.
`timescale 1ns / 1ps

module thmj_weight
    import thmj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  beat_ctrl_t            in_ctrl,
    input  logic [NODE_IDX_W-1:0] node,
    input  factor_t               t_ksi,
    input  factor_t               t_nu,
    input  factor_t               t_etta,
    output beat_ctrl_t            out_ctrl,
    output weight_t               w_ksi,
    output weight_t               w_nu,
    output weight_t               w_etta,
    output weight_t               w_map
);

    factor_t fa;
    factor_t fb;
    factor_t fc;

    beat_ctrl_t            ctrl1_reg;
    logic [NODE_IDX_W-1:0] node1_reg;
    factor_t               c1_reg;
    prod_u_t               p_bc1_reg;
    prod_u_t               p_ac1_reg;
    prod_u_t               p_ab1_reg;

    factor_t w_ab;
    prod_u_t p3_next;

    beat_ctrl_t            ctrl2_reg;
    logic [NODE_IDX_W-1:0] node2_reg;
    factor_t               wbc2_reg;
    factor_t               wac2_reg;
    factor_t               wab2_reg;
    prod_u_t               p3_2_reg;

    // Pick t or 1 - t from the corner bits
    always_comb
    begin
        fa = node[0] ? t_ksi  : FW'(ONE) - t_ksi;
        fb = node[1] ? t_nu   : FW'(ONE) - t_nu;
        fc = node[2] ? t_etta : FW'(ONE) - t_etta;
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl1_reg <= '0;
        else
            ctrl1_reg <= in_ctrl;
    end

    // Stage 1: pairwise factor products
    always_ff @(posedge clk)
    begin
        node1_reg <= node;
        c1_reg    <= fc;
        p_bc1_reg <= PROD_W'(fb) * PROD_W'(fc);
        p_ac1_reg <= PROD_W'(fa) * PROD_W'(fc);
        p_ab1_reg <= PROD_W'(fa) * PROD_W'(fb);
    end

    // Round the ksi-nu product and scale it by the etta factor
    always_comb
    begin
        w_ab    = rnd_q(p_ab1_reg);
        p3_next = PROD_W'(w_ab) * PROD_W'(c1_reg);
    end

    // Stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl2_reg <= '0;
        else
            ctrl2_reg <= ctrl1_reg;
    end

    // Stage 2: rounded derivative magnitudes and shape product
    always_ff @(posedge clk)
    begin
        node2_reg <= node1_reg;
        wbc2_reg  <= rnd_q(p_bc1_reg);
        wac2_reg  <= rnd_q(p_ac1_reg);
        wab2_reg  <= w_ab;
        p3_2_reg  <= p3_next;
    end

    // Apply signs: minus where the corner bit is clear
    always_comb
    begin
        w_ksi  = node2_reg[0] ? WW'(wbc2_reg) : WW'(0) - WW'(wbc2_reg);
        w_nu   = node2_reg[1] ? WW'(wac2_reg) : WW'(0) - WW'(wac2_reg);
        w_etta = node2_reg[2] ? WW'(wab2_reg) : WW'(0) - WW'(wab2_reg);
        w_map  = WW'(rnd_q(p3_2_reg));
    end

    assign out_ctrl = ctrl2_reg;

endmodule

>>> src/thmj_mac.sv
// Twelve multiply-accumulators: coordinate times weight, summed over the
// eight node beats, then rounded. Depends on thmj_pkg.
`timescale 1ns / 1ps

module thmj_mac
    import thmj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  beat_ctrl_t in_ctrl,
    input  node_t      coord,
    input  weight_t    w_ksi,
    input  weight_t    w_nu,
    input  weight_t    w_etta,
    input  weight_t    w_map,
    input  logic       clear,
    output logic       done,
    output out_word_t  res [OUT_FIELDS]
);

    coord_t  coord_arr [AXES];
    weight_t w_arr [WEIGHT_KINDS];

    beat_ctrl_t ctrl_a_reg;
    prod_s_t    prod_reg [OUT_FIELDS];
    acc_t       acc_reg [OUT_FIELDS];
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        coord_arr[0] = coord.x;
        coord_arr[1] = coord.y;
        coord_arr[2] = coord.z;
        w_arr[0]     = w_ksi;
        w_arr[1]     = w_nu;
        w_arr[2]     = w_etta;
        w_arr[3]     = w_map;
    end

    // Product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_a_reg <= '0;
        else
            ctrl_a_reg <= in_ctrl;
    end

    // Register the twelve products
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < WEIGHT_KINDS; d++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_reg[d*AXES+a] <= PW'(coord_arr[a]) * PW'(w_arr[d]);
            end
        end
    end

    // Accumulate: restart on the first node beat
    always_ff @(posedge clk)
    begin
        if (ctrl_a_reg.valid)
        begin
            for (int i = 0; i < OUT_FIELDS; i++)
            begin
                if (ctrl_a_reg.first)
                    acc_reg[i] <= ACC_W'(prod_reg[i]);
                else
                    acc_reg[i] <= acc_reg[i] + ACC_W'(prod_reg[i]);
            end
        end
    end

    // Flag the sums complete after the last node beat; drop when taken
    always_comb
    begin
        done_next = done_reg;
        if (ctrl_a_reg.valid && ctrl_a_reg.last)
            done_next = 1'b1;
        else if (clear)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    // Round each sum to signed Q24.16, dropping 16 fraction bits
    always_comb
    begin
        for (int i = 0; i < OUT_FIELDS; i++)
            res[i] = rnd_out(acc_reg[i]);
    end

    assign done = done_reg;

endmodule
